// ===== rtl/blit_rect_check_and_plan_assert.svh =====
// Assertion macros for the blit check-and-plan block.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef BLIT_RECT_CHECK_AND_PLAN_ASSERT_SVH
`define BLIT_RECT_CHECK_AND_PLAN_ASSERT_SVH

// property must hold at every edge outside reset
`define BRCP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("brcp assertion failed");

// expression must never be true outside reset
`define BRCP_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("brcp forbidden condition seen");

`endif

// ===== rtl/brcp_pkg.sv =====
// Shared types and constants for the blit check-and-plan block.
// No dependencies.
package brcp_pkg;

   // coordinate and size limit, inclusive
   localparam int unsigned COORD_LIMIT = 16383;

   localparam int COORD_W = 16;
   localparam int SUM_W   = COORD_W + 1;
   localparam int DIM_W   = 14;
   localparam int PROD_W  = SUM_W + DIM_W;
   localparam int XW4_W   = SUM_W + 2;
   localparam int WORD_W  = 32;

   localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(COORD_LIMIT);

   // plan queue
   localparam int QDEPTH   = 4;
   localparam int Q_PTR_W  = $clog2(QDEPTH);
   localparam int Q_CNT_W  = Q_PTR_W + 1;

   // register map
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SURFACE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SURFACE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_PITCH      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_BASE       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_SPAN       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VIDEO_MEM_BYTES = 3'd5;

   localparam logic CMD_FILL = 1'b0;
   localparam logic CMD_COPY = 1'b1;

   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_BAD_SURFACE = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [COORD_W-1:0] dst_x;
      logic [COORD_W-1:0] dst_y;
      logic [COORD_W-1:0] src_x;
      logic [COORD_W-1:0] src_y;
      logic [COORD_W-1:0] rect_width;
      logic [COORD_W-1:0] rect_height;
      logic [WORD_W-1:0]  brush_color;
   } req_type;

   typedef struct packed {
      logic              status;
      logic              uses_source;
      logic              left_to_right;
      logic              top_to_bottom;
      logic [WORD_W-1:0] dst_corner_word;
      logic [WORD_W-1:0] src_corner_word;
      logic [WORD_W-1:0] size_word;
      logic [WORD_W-1:0] dst_pitch_word;
      logic [WORD_W-1:0] src_pitch_word;
      logic [WORD_W-1:0] color_out;
   } rsp_type;

   // live configuration plus derived headroom (video_mem_bytes - scan_base)
   typedef struct packed {
      logic [DIM_W-1:0]  surface_width;
      logic [DIM_W-1:0]  surface_height;
      logic [DIM_W-1:0]  line_pitch;
      logic [WORD_W-1:0] scan_base;
      logic [WORD_W-1:0] scan_span;
      logic [WORD_W-1:0] mem_room;
      logic              room_neg;
   } cfg_type;

   // checked command waiting for the back end
   typedef struct packed {
      req_type req;
      logic    bad;
   } plan_type;

   typedef struct packed {
      logic a_busy;
   } front_stat_type;

   typedef struct packed {
      logic               not_empty;
      logic [Q_CNT_W-1:0] count;
   } q_stat_type;

endpackage

// ===== rtl/brcp_front.sv =====
// Front end: takes commands, runs the rectangle checks over two stages.
// Depends on brcp_pkg.
module brcp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_take,
   input  brcp_pkg::req_type        in_req,
   input  brcp_pkg::cfg_type        cfg,
   output logic                     push_valid,
   output brcp_pkg::plan_type       push_plan,
   output brcp_pkg::front_stat_type stat
);

   typedef struct packed {
      logic                          bad;
      logic [brcp_pkg::PROD_W-1:0]   prod;
      logic [brcp_pkg::XW4_W-1:0]    xw4;
   } rect_chk_type;

   typedef struct packed {
      brcp_pkg::req_type req;
      rect_chk_type      dst;
      rect_chk_type      src;
   } stage_a_type;

   function automatic rect_chk_type check_rect(
      input logic [brcp_pkg::COORD_W-1:0] x,
      input logic [brcp_pkg::COORD_W-1:0] y,
      input logic [brcp_pkg::COORD_W-1:0] w,
      input logic [brcp_pkg::COORD_W-1:0] h,
      input brcp_pkg::cfg_type            c
   );
      rect_chk_type                r;
      logic [brcp_pkg::SUM_W-1:0]  xe;
      logic [brcp_pkg::SUM_W-1:0]  ye;
      xe = {1'b0, x} + {1'b0, w};
      ye = {1'b0, y} + {1'b0, h};
      r.bad = (w == '0) || (h == '0) ||
              (x > brcp_pkg::COORD_MAX) || (y > brcp_pkg::COORD_MAX) ||
              (w > brcp_pkg::COORD_MAX) || (h > brcp_pkg::COORD_MAX) ||
              (xe > brcp_pkg::SUM_W'(c.surface_width)) ||
              (ye > brcp_pkg::SUM_W'(c.surface_height)) ||
              ({w, 2'b00} > (brcp_pkg::COORD_W + 2)'(c.line_pitch));
      // last line start offset; garbage when h is zero, but then bad is set
      r.prod = brcp_pkg::PROD_W'(ye - brcp_pkg::SUM_W'(1)) *
               brcp_pkg::PROD_W'(c.line_pitch);
      r.xw4  = {xe, 2'b00};
      return r;
   endfunction

   function automatic logic span_fail(
      input rect_chk_type      r,
      input brcp_pkg::cfg_type c
   );
      logic [brcp_pkg::WORD_W-1:0] last;
      last = brcp_pkg::WORD_W'(r.prod) + brcp_pkg::WORD_W'(r.xw4);
      return (last > c.scan_span) || c.room_neg || (last > c.mem_room);
   endfunction

   logic              a_valid_ff, a_valid_in;
   stage_a_type       a_ff, a_in;
   rect_chk_type      src_chk;
   logic              is_copy;

   always_comb begin
      a_valid_in  = in_take;
      a_in.req    = in_req;
      a_in.dst    = check_rect(in_req.dst_x, in_req.dst_y, in_req.rect_width,
                               in_req.rect_height, cfg);
      src_chk     = check_rect(in_req.src_x, in_req.src_y, in_req.rect_width,
                               in_req.rect_height, cfg);
      a_in.src    = src_chk;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      a_ff <= a_in;
   end

   // second stage: span and memory bounds, straight into the queue
   assign is_copy    = (a_ff.req.cmd == brcp_pkg::CMD_COPY);
   assign push_valid = a_valid_ff;
   always_comb begin
      push_plan.req = a_ff.req;
      push_plan.bad = a_ff.dst.bad || span_fail(a_ff.dst, cfg) ||
                      (is_copy && (a_ff.src.bad || span_fail(a_ff.src, cfg)));
   end

   assign stat.a_busy = a_valid_ff;

endmodule

// ===== rtl/brcp_queue.sv =====
// Short plan queue between the check front end and the packing back end.
// Depends on brcp_pkg.
module brcp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  brcp_pkg::plan_type   push_plan,
   input  logic                 pop_ready,
   output brcp_pkg::plan_type   head,
   output brcp_pkg::q_stat_type stat
);

   brcp_pkg::plan_type                entry_ff [brcp_pkg::QDEPTH];
   logic [brcp_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [brcp_pkg::Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [brcp_pkg::Q_CNT_W-1:0]      count_ff, count_in;
   logic                              do_pop;

   assign do_pop = pop_ready && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + brcp_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + brcp_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      case ({push_valid, do_pop})
         2'b10:   count_in = count_ff + brcp_pkg::Q_CNT_W'(1);
         2'b01:   count_in = count_ff - brcp_pkg::Q_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_plan;
      end
   end

   assign head           = entry_ff[rd_ptr_ff];
   assign stat.not_empty = (count_ff != '0);
   assign stat.count     = count_ff;

endmodule

// ===== rtl/brcp_back.sv =====
// Back end: picks scan direction, packs engine words, holds the result word.
// Depends on brcp_pkg.
module brcp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  brcp_pkg::plan_type   head,
   input  brcp_pkg::q_stat_type q_stat,
   input  brcp_pkg::cfg_type    cfg,
   output logic                 pop_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output brcp_pkg::rsp_type    out_rsp
);

   function automatic brcp_pkg::rsp_type plan_rsp(
      input brcp_pkg::plan_type p,
      input brcp_pkg::cfg_type  c
   );
      brcp_pkg::rsp_type              r;
      logic [brcp_pkg::WORD_W-1:0]    pitch_word;
      logic [brcp_pkg::COORD_W-1:0]   dx, dy, sx, sy, w, h;
      logic [brcp_pkg::SUM_W-1:0]     sy_end, dy_end, sx_end;
      logic                           vert, horz;
      dx = p.req.dst_x;
      dy = p.req.dst_y;
      sx = p.req.src_x;
      sy = p.req.src_y;
      w  = p.req.rect_width;
      h  = p.req.rect_height;
      sy_end = {1'b0, sy} + {1'b0, h};
      dy_end = {1'b0, dy} + {1'b0, h};
      sx_end = {1'b0, sx} + {1'b0, w};
      vert = ({1'b0, dy} < sy_end) && ({1'b0, sy} < dy_end) && (dy > sy);
      horz = (dy == sy) && (dx > sx) && ({1'b0, dx} < sx_end);
      pitch_word = {2'b00, c.line_pitch[brcp_pkg::DIM_W-1:6], c.scan_base[31:10]};
      r = '0;
      if (p.bad) begin
         r.status = brcp_pkg::STATUS_BAD_SURFACE;
      end else if (p.req.cmd == brcp_pkg::CMD_FILL) begin
         r.status          = brcp_pkg::STATUS_OK;
         r.left_to_right   = 1'b1;
         r.top_to_bottom   = 1'b1;
         r.dst_corner_word = {dy, dx};
         r.size_word       = {h, w};
         r.dst_pitch_word  = pitch_word;
         r.color_out       = p.req.brush_color;
      end else begin
         // overlapping copy: walk from the far edge so source is read first
         if (vert) begin
            dy = dy + h - brcp_pkg::COORD_W'(1);
            sy = sy + h - brcp_pkg::COORD_W'(1);
         end else if (horz) begin
            dx = dx + w - brcp_pkg::COORD_W'(1);
            sx = sx + w - brcp_pkg::COORD_W'(1);
         end
         r.status          = brcp_pkg::STATUS_OK;
         r.uses_source     = 1'b1;
         r.left_to_right   = vert || !horz;
         r.top_to_bottom   = !vert;
         r.dst_corner_word = {dy, dx};
         r.src_corner_word = {sy, sx};
         r.size_word       = {h, w};
         r.dst_pitch_word  = pitch_word;
         r.src_pitch_word  = pitch_word;
      end
      return r;
   endfunction

   logic              valid_ff, valid_in;
   brcp_pkg::rsp_type rsp_ff, rsp_in;
   logic              do_pop;

   assign pop_ready = !valid_ff || out_ready;
   assign do_pop    = pop_ready && q_stat.not_empty;

   always_comb begin
      valid_in = do_pop ? 1'b1 : (valid_ff && !out_ready);
      rsp_in   = do_pop ? plan_rsp(head, cfg) : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ===== rtl/blit_rect_check_and_plan.sv =====
// Blit check-and-plan top: config registers, front/queue/back and credit.
// A command passes the stage A register, the plan queue and the output register.
// Throughput: one command per cycle; ready is held by the 4-entry plan queue
// credit (queue occupancy plus the front stage in flight).
// Reset: synchronous, active high; clears valids, queue pointers and restores
// register defaults. Depends on brcp_pkg, brcp_front, brcp_queue, brcp_back.
module blit_rect_check_and_plan (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  brcp_pkg::req_type                  req_data,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output brcp_pkg::rsp_type                  rsp_data,
   // register write port
   input  logic                               csr_we,
   input  logic [brcp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [brcp_pkg::WORD_W-1:0]        csr_wdata
);

`include "blit_rect_check_and_plan_assert.svh"

   // ---------------------------------------------------------------
   // Configuration registers. Writes land only while the block is idle, as a
   // rule for the user; the block itself does not enforce it. The derived
   // memory headroom is registered from vmem and base, so it trails a write:
   // a command accepted right after a write reaches the span check after stage A, when the headroom has caught up.
   // ---------------------------------------------------------------
   logic [brcp_pkg::DIM_W-1:0]  sw_ff, sw_in;
   logic [brcp_pkg::DIM_W-1:0]  sh_ff, sh_in;
   logic [brcp_pkg::DIM_W-1:0]  pitch_ff, pitch_in;
   logic [brcp_pkg::WORD_W-1:0] base_ff, base_in;
   logic [brcp_pkg::WORD_W-1:0] span_ff, span_in;
   logic [brcp_pkg::WORD_W-1:0] vmem_ff, vmem_in;
   logic [brcp_pkg::WORD_W:0]   room_ff, room_in;

   always_comb begin
      sw_in    = sw_ff;
      sh_in    = sh_ff;
      pitch_in = pitch_ff;
      base_in  = base_ff;
      span_in  = span_ff;
      vmem_in  = vmem_ff;
      if (csr_we) begin
         unique case (csr_index)
            brcp_pkg::CSR_SURFACE_WIDTH:   sw_in    = csr_wdata[brcp_pkg::DIM_W-1:0];
            brcp_pkg::CSR_SURFACE_HEIGHT:  sh_in    = csr_wdata[brcp_pkg::DIM_W-1:0];
            brcp_pkg::CSR_LINE_PITCH:      pitch_in = csr_wdata[brcp_pkg::DIM_W-1:0];
            brcp_pkg::CSR_SCAN_BASE:       base_in  = csr_wdata;
            brcp_pkg::CSR_SCAN_SPAN:       span_in  = csr_wdata;
            brcp_pkg::CSR_VIDEO_MEM_BYTES: vmem_in  = csr_wdata;
            default:                       ;  // unmapped index, dropped
         endcase
      end
      // base + last <= vmem  <=>  base <= vmem and last <= vmem - base
      room_in = {1'b0, vmem_ff} - {1'b0, base_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff    <= brcp_pkg::DIM_W'(1024);
         sh_ff    <= brcp_pkg::DIM_W'(768);
         pitch_ff <= brcp_pkg::DIM_W'(4096);
         base_ff  <= '0;
         span_ff  <= brcp_pkg::WORD_W'(3145728);
         vmem_ff  <= brcp_pkg::WORD_W'(16777216);
         room_ff  <= (brcp_pkg::WORD_W + 1)'(16777216);
      end else begin
         sw_ff    <= sw_in;
         sh_ff    <= sh_in;
         pitch_ff <= pitch_in;
         base_ff  <= base_in;
         span_ff  <= span_in;
         vmem_ff  <= vmem_in;
         room_ff  <= room_in;
      end
   end

   brcp_pkg::cfg_type cfg;
   always_comb begin
      cfg.surface_width  = sw_ff;
      cfg.surface_height = sh_ff;
      cfg.line_pitch     = pitch_ff;
      cfg.scan_base      = base_ff;
      cfg.scan_span      = span_ff;
      cfg.mem_room       = room_ff[brcp_pkg::WORD_W-1:0];
      cfg.room_neg       = room_ff[brcp_pkg::WORD_W];
   end

   // ---------------------------------------------------------------
   // Front end: stage A does the bound checks and the pitch multiply,
   // stage B adds up the last byte and compares it against span and
   // memory, then writes the plan queue.
   // ---------------------------------------------------------------
   logic                     in_take;
   logic                     push_valid;
   brcp_pkg::plan_type       push_plan;
   brcp_pkg::front_stat_type front_stat;

   assign in_take = req_valid && req_ready;

   brcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_take    (in_take),
      .in_req     (req_data),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_plan  (push_plan),
      .stat       (front_stat)
   );

   // ---------------------------------------------------------------
   // Plan queue. The front never stalls once a command is in; ready
   // reserves a slot for every command still in stage A, so the queue
   // can always absorb a push.
   // ---------------------------------------------------------------
   logic                 pop_ready;
   brcp_pkg::plan_type   head;
   brcp_pkg::q_stat_type q_stat;
   logic [brcp_pkg::Q_CNT_W-1:0] committed;

   brcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_plan  (push_plan),
      .pop_ready  (pop_ready),
      .head       (head),
      .stat       (q_stat)
   );

   assign committed = q_stat.count + brcp_pkg::Q_CNT_W'(front_stat.a_busy);
   assign req_ready = (committed < brcp_pkg::Q_CNT_W'(brcp_pkg::QDEPTH));

   // ---------------------------------------------------------------
   // Back end: direction pick and word packing into the output register;
   // it drains the queue whenever the output register is free or taken.
   // ---------------------------------------------------------------
   brcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_stat    (q_stat),
      .cfg       (cfg),
      .pop_ready (pop_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (rsp_data)
   );

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // credit must keep the queue from overflowing on a stage B push
   `BRCP_NEVER(a_queue_overrun, push_valid && !pop_ready &&
      (q_stat.count == brcp_pkg::Q_CNT_W'(brcp_pkg::QDEPTH)))
   // a rejected word carries nothing but its status
   `BRCP_ASSERT(a_reject_clean, rsp_valid && rsp_data.status |->
      (rsp_data.size_word == '0) && (rsp_data.dst_pitch_word == '0) &&
      !rsp_data.left_to_right && !rsp_data.top_to_bottom && !rsp_data.uses_source)
   // a fill scans forward and has no source words
   `BRCP_ASSERT(a_fill_plan, rsp_valid && !rsp_data.status && !rsp_data.uses_source |->
      rsp_data.left_to_right && rsp_data.top_to_bottom &&
      (rsp_data.src_corner_word == '0) && (rsp_data.src_pitch_word == '0))
   // at most one scan axis gets reversed
   `BRCP_ASSERT(a_one_reverse, rsp_valid && !rsp_data.status |->
      rsp_data.left_to_right || rsp_data.top_to_bottom)

endmodule

// ===== tb/blit_plan_board_pkg.sv =====
// Scoreboard class for the blit check-and-plan testbench: predicts the plan word
// for each accepted command and checks the block's result words in order.
// Depends on brcp_pkg for the word types, register indexes and codes.
package blit_plan_board_pkg;
   import brcp_pkg::*;

   class blit_plan_board;
      logic [DIM_W-1:0]  surf_w;
      logic [DIM_W-1:0]  surf_h;
      logic [DIM_W-1:0]  pitch;
      logic [WORD_W-1:0] base;
      logic [WORD_W-1:0] span;
      logic [WORD_W-1:0] vmem;
      rsp_type           plans[$];
      int unsigned       errs;

      function new();
         surf_w = 14'd1024;
         surf_h = 14'd768;
         pitch  = 14'd4096;
         base   = 32'd0;
         span   = 32'd3145728;
         vmem   = 32'd16777216;
         errs   = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] v);
         case (idx)
            CSR_SURFACE_WIDTH:   surf_w = v[DIM_W-1:0];
            CSR_SURFACE_HEIGHT:  surf_h = v[DIM_W-1:0];
            CSR_LINE_PITCH:      pitch  = v[DIM_W-1:0];
            CSR_SCAN_BASE:       base   = v;
            CSR_SCAN_SPAN:       span   = v;
            CSR_VIDEO_MEM_BYTES: vmem   = v;
            default: ;
         endcase
      endfunction

      // bounds check, all math in 64 bits so nothing wraps
      function bit rect_ok(logic [63:0] x, logic [63:0] y, logic [63:0] w, logic [63:0] h);
         logic [63:0] end_byte;
         if (w == 0 || h == 0 || x > COORD_LIMIT || y > COORD_LIMIT ||
             w > COORD_LIMIT || h > COORD_LIMIT)
            return 1'b0;
         if (x > surf_w || w > surf_w - x || y > surf_h || h > surf_h - y)
            return 1'b0;
         end_byte = (y + h - 1) * pitch + (x + w) * 4;
         if (w * 4 > pitch || end_byte > span)
            return 1'b0;
         return (64'(base) + end_byte) <= 64'(vmem);
      endfunction

      function logic [WORD_W-1:0] pitch_word();
         return (base >> 10) | ((32'(pitch) >> 6) << 22);
      endfunction

      function logic [WORD_W-1:0] yx_word(logic [63:0] row, logic [63:0] col);
         return {row[15:0], col[15:0]};
      endfunction

      function rsp_type plan(req_type c);
         rsp_type     r;
         logic [63:0] dx, dy, sx, sy, w, h;
         r  = '0;
         dx = 64'(c.dst_x);
         dy = 64'(c.dst_y);
         sx = 64'(c.src_x);
         sy = 64'(c.src_y);
         w  = 64'(c.rect_width);
         h  = 64'(c.rect_height);
         if (!rect_ok(dx, dy, w, h) || (c.cmd == CMD_COPY && !rect_ok(sx, sy, w, h))) begin
            r.status = STATUS_BAD_SURFACE;
            return r;
         end
         r.status         = STATUS_OK;
         r.size_word      = yx_word(h, w);
         r.dst_pitch_word = pitch_word();
         r.left_to_right  = 1'b1;
         r.top_to_bottom  = 1'b1;
         if (c.cmd == CMD_FILL) begin
            r.dst_corner_word = yx_word(dy, dx);
            r.color_out       = c.brush_color;
            return r;
         end
         // overlapping copy: start from the far edge
         if (dy < sy + h && sy < dy + h && dy > sy) begin
            r.top_to_bottom = 1'b0;
            sy = sy + h - 1;
            dy = dy + h - 1;
         end else if (dy == sy && dx > sx && dx < sx + w) begin
            r.left_to_right = 1'b0;
            sx = sx + w - 1;
            dx = dx + w - 1;
         end
         r.uses_source     = 1'b1;
         r.dst_corner_word = yx_word(dy, dx);
         r.src_corner_word = yx_word(sy, sx);
         r.src_pitch_word  = pitch_word();
         return r;
      endfunction

      function void note_cmd(req_type c);
         plans.push_back(plan(c));
      endfunction

      function int pending();
         return plans.size();
      endfunction

      function void cmp(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
         if (got !== want) begin
            errs++;
            if (errs <= 10)
               $display("mismatch on %s: expected %h, got %h", name, want, got);
         end
      endfunction

      function void check_rsp(rsp_type got);
         rsp_type want;
         if (plans.size() == 0) begin
            errs++;
            if (errs <= 10)
               $display("result word with no command pending: %h", got);
            return;
         end
         want = plans.pop_front();
         cmp("status",          want.status,          got.status);
         cmp("uses_source",     want.uses_source,     got.uses_source);
         cmp("left_to_right",   want.left_to_right,   got.left_to_right);
         cmp("top_to_bottom",   want.top_to_bottom,   got.top_to_bottom);
         cmp("dst_corner_word", want.dst_corner_word, got.dst_corner_word);
         cmp("src_corner_word", want.src_corner_word, got.src_corner_word);
         cmp("size_word",       want.size_word,       got.size_word);
         cmp("dst_pitch_word",  want.dst_pitch_word,  got.dst_pitch_word);
         cmp("src_pitch_word",  want.src_pitch_word,  got.src_pitch_word);
         cmp("color_out",       want.color_out,       got.color_out);
      endfunction
   endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench for blit_rect_check_and_plan: directed and random commands
// under several register settings, random stalls on both channels.
// Depends on brcp_pkg, blit_plan_board_pkg and the block's RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import brcp_pkg::*;
   import blit_plan_board_pkg::*;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_wdata = '0;

   // high while both sides run without idle cycles
   bit steady = 1'b0;

   blit_plan_board sb = new();

   blit_rect_check_and_plan dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver: stalls about a third of the time unless in a steady stretch
   always @(negedge clock) begin
      rsp_ready <= !reset && (steady || $urandom_range(0, 99) >= 33);
   end

   // every result word is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_rsp(rsp_data);
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic req_type make_cmd(logic cmd, int dx, int dy, int sx, int sy,
                                        int w, int h, logic [WORD_W-1:0] color);
      req_type c;
      c.cmd         = cmd;
      c.dst_x       = 16'(dx);
      c.dst_y       = 16'(dy);
      c.src_x       = 16'(sx);
      c.src_y       = 16'(sy);
      c.rect_width  = 16'(w);
      c.rect_height = 16'(h);
      c.brush_color = color;
      return c;
   endfunction

   // values at and around the coordinate limit, plus zero, one, all ones and noise
   function automatic logic [COORD_W-1:0] boundary_coord();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'(COORD_LIMIT);
         3: return 16'(COORD_LIMIT + 1);
         4: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // signed offset in [-(n-1), n-1], used to build overlapping copies
   function automatic int jitter(int n);
      return int'($urandom_range(0, 2 * n - 2)) - (n - 1);
   endfunction

   // Mostly rectangles that fit the current surface, so the overlap and
   // span/memory checks get exercised; the rest is raw noise, boundary
   // values and rectangles pushed one pixel off the surface.
   function automatic req_type rand_cmd();
      req_type c;
      int      pick, sw_i, sh_i, wmax, hmax, w, h, dx, dy, sx, sy;
      pick          = $urandom_range(0, 99);
      c.cmd         = $urandom_range(0, 1) ? CMD_COPY : CMD_FILL;
      c.brush_color = $urandom();
      if (pick < 15) begin
         c.dst_x       = 16'($urandom());
         c.dst_y       = 16'($urandom());
         c.src_x       = 16'($urandom());
         c.src_y       = 16'($urandom());
         c.rect_width  = 16'($urandom());
         c.rect_height = 16'($urandom());
         return c;
      end
      if (pick < 22) begin
         c.dst_x       = boundary_coord();
         c.dst_y       = boundary_coord();
         c.src_x       = boundary_coord();
         c.src_y       = boundary_coord();
         c.rect_width  = boundary_coord();
         c.rect_height = boundary_coord();
         return c;
      end
      sw_i = sb.surf_w;
      sh_i = sb.surf_h;
      wmax = sb.pitch / 4;
      if (wmax > sw_i) wmax = sw_i;
      hmax = sh_i;
      w  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, wmax)
                                       : $urandom_range(1, (wmax < 32) ? wmax : 32);
      h  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, hmax)
                                       : $urandom_range(1, (hmax < 32) ? hmax : 32);
      dx = $urandom_range(0, sw_i - w);
      dy = $urandom_range(0, sh_i - h);
      if (pick < 26)
         dx = sw_i - w + 1;
      else if (pick < 30)
         dy = sh_i - h + 1;
      case ($urandom_range(0, 3))
         0: begin
            sx = $urandom_range(0, sw_i - w);
            sy = $urandom_range(0, sh_i - h);
         end
         1: begin   // overlapping in both axes
            sx = clamp(dx + jitter(w), 0, sw_i - w);
            sy = clamp(dy + jitter(h), 0, sh_i - h);
         end
         2: begin   // same line, source left or right
            sy = dy;
            sx = clamp(dx + jitter(w + 1), 0, sw_i - w);
         end
         default: begin
            sx = dx;
            sy = dy;
         end
      endcase
      c.dst_x       = 16'(dx);
      c.dst_y       = 16'(dy);
      c.src_x       = 16'(sx);
      c.src_y       = 16'(sy);
      c.rect_width  = 16'(w);
      c.rect_height = 16'(h);
      return c;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_cmd(input req_type c);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_cmd(c);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      sb.set_reg(idx, v);
      @(negedge clock);
   endtask

   // Drain, reprogram all registers, then push n random words. The first
   // n_steady words go with no idling on either side.
   task automatic run_phase(input logic [WORD_W-1:0] sw, input logic [WORD_W-1:0] sh,
                            input logic [WORD_W-1:0] lp, input logic [WORD_W-1:0] base,
                            input logic [WORD_W-1:0] span, input logic [WORD_W-1:0] vmem,
                            input int n, input int n_steady);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      write_reg(CSR_SURFACE_WIDTH,   sw);
      write_reg(CSR_SURFACE_HEIGHT,  sh);
      write_reg(CSR_LINE_PITCH,      lp);
      write_reg(CSR_SCAN_BASE,       base);
      write_reg(CSR_SCAN_SPAN,       span);
      write_reg(CSR_VIDEO_MEM_BYTES, vmem);
      csr_we <= 1'b0;
      for (int k = 0; k < n; k++) begin
         steady = (k < n_steady);
         send_cmd(rand_cmd());
      end
      steady = 1'b0;
   endtask

   initial begin
      logic [WORD_W-1:0] r_base, r_span, r_vmem;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words on the reset settings: 1024x768, pitch 4096
      send_cmd(make_cmd(CMD_FILL, 0, 0, 0, 0, 1, 1, 32'hFFFF_FFFF));
      send_cmd(make_cmd(CMD_FILL, 0, 0, 0, 0, 1024, 768, 32'h0));     // ends exactly at span
      send_cmd(make_cmd(CMD_FILL, 1023, 767, 0, 0, 1, 1, 32'hA5A5_A5A5));
      send_cmd(make_cmd(CMD_FILL, 5, 5, 0, 0, 0, 4, 32'h1));           // zero width
      send_cmd(make_cmd(CMD_FILL, 5, 5, 0, 0, 4, 0, 32'h2));           // zero height
      send_cmd(make_cmd(CMD_FILL, 1024, 0, 0, 0, 1, 1, 32'h3));        // off the right side
      send_cmd(make_cmd(CMD_FILL, 0, 0, 0, 0, 1025, 1, 32'h4));        // wider than surface
      send_cmd(make_cmd(CMD_FILL, 16384, 0, 0, 0, 1, 1, 32'h5));       // x past the limit
      send_cmd(make_cmd(CMD_FILL, 65535, 65535, 65535, 65535, 65535, 65535, 32'h6));
      send_cmd(make_cmd(CMD_FILL, 0, 0, 0, 0, 16383, 16383, 32'h7));
      send_cmd(make_cmd(CMD_FILL, 8, 8, 65535, 65535, 16, 16, 32'h5A5A_5A5A)); // src ignored
      send_cmd(make_cmd(CMD_COPY, 100, 100, 0, 0, 10, 10, 32'hDEAD_BEEF));  // color ignored
      send_cmd(make_cmd(CMD_COPY, 12, 20, 10, 10, 30, 20, 32'h0));     // dst lower: bottom-up
      send_cmd(make_cmd(CMD_COPY, 10, 10, 12, 20, 30, 20, 32'h0));     // dst higher
      send_cmd(make_cmd(CMD_COPY, 10, 30, 10, 10, 30, 20, 32'h0));     // just below, no overlap
      send_cmd(make_cmd(CMD_COPY, 15, 50, 10, 50, 20, 5, 32'h0));      // same line: right-to-left
      send_cmd(make_cmd(CMD_COPY, 30, 50, 10, 50, 20, 5, 32'h0));      // same line, touching
      send_cmd(make_cmd(CMD_COPY, 10, 50, 15, 50, 20, 5, 32'h0));      // same line, dst left
      send_cmd(make_cmd(CMD_COPY, 40, 40, 40, 40, 8, 8, 32'h0));       // src equals dst
      send_cmd(make_cmd(CMD_COPY, 0, 0, 2000, 0, 8, 8, 32'h0));        // bad source
      send_cmd(make_cmd(CMD_COPY, 0, 0, 0, 16384, 8, 8, 32'h0));       // source y past limit
      send_cmd(make_cmd(CMD_COPY, 0, 1, 0, 0, 1024, 767, 32'h0));      // full-height overlap
      send_cmd(make_cmd(CMD_COPY, 90, 105, 100, 100, 20, 10, 32'h0));  // diagonal overlap

      // small surface, roomy memory; first stretch runs without idling
      run_phase(64, 48, 256, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 200, 120);
      // large surface and the largest pitch that is a multiple of 64
      run_phase(8192, 8192, 16320, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 150, 0);
      // scanout at the top of memory: only tiny rectangles fit
      run_phase(200, 100, 1024, 32'hFFFF_FC00, 300000, 32'hFFFF_FFFF, 100, 0);
      // one-pixel surface, minimum pitch
      run_phase(1, 1, 64, 0, 4, 4, 60, 0);
      // pitch not a multiple of 64, tight span and memory
      run_phase(25, 40, 100, 5120, 3000, 8000, 150, 0);
      // zero span: everything is refused
      run_phase(100, 100, 512, 1024, 0, 1, 40, 0);
      // random settings
      repeat (4) begin
         r_base = $urandom_range(0, 1) ? ($urandom_range(0, 1023) << 10)
                                       : ($urandom_range(0, 4194303) << 10);
         r_span = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 8000000);
         r_vmem = $urandom_range(0, 1) ? r_base + $urandom_range(1, 16000000) : $urandom();
         if (r_vmem == 0) r_vmem = 1;
         run_phase($urandom_range(1, 8192), $urandom_range(1, 8192), $urandom_range(64, 16320),
                   r_base, r_span, r_vmem, 90, 0);
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      // keep running to catch stray result words
      repeat (10) @(negedge clock);
      if (sb.errs == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
